// File: rtl/cds_pkg.sv
// Shared types, constants and calendar functions for the calendar date stepper.
// Depends on nothing; the top level and the testbench files import it.
package cds_pkg;

    // Command codes carried in the slave-side tuser.
    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_FWD  = 2'd1,
        CMD_BACK = 2'd2
    } t_cmd;

    localparam int unsigned BASE_YEAR = 1900;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] DAYS_31 = 5'd31;
    localparam logic [4:0] DAYS_30 = 5'd30;
    localparam logic [4:0] DAYS_29 = 5'd29;
    localparam logic [4:0] DAYS_28 = 5'd28;

    // Multiplicative inverse of 25 modulo 2^32, and the largest quotient that
    // a multiple of 25 can give: x is a multiple of 25 exactly when
    // x * INV25 (mod 2^32) is no greater than MUL25_LIMIT.
    localparam logic [31:0] INV25       = 32'hC28F_5C29;
    localparam logic [31:0] MUL25_LIMIT = 32'hFFFF_FFFF / 32'd25;

    // Gregorian leap rule. A multiple of 100 is a multiple of 4 and of 25,
    // and a multiple of 400 is a multiple of 16 and of 25.
    function automatic logic leap_year(input logic [31:0] year);
        logic [31:0] prod;
        logic        by25;
        begin
            prod = year * INV25;
            by25 = (prod <= MUL25_LIMIT);
            return (year[1:0] == 2'b00) && (!by25 || (year[3:0] == 4'b0000));
        end
    endfunction

    // Length of a month; a month code outside 1..12 gives 31.
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            if (month == MONTH_FEB) begin
                len = leap ? DAYS_29 : DAYS_28;
            end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
                len = DAYS_30;
            end else begin
                len = DAYS_31;
            end
            return len;
        end
    endfunction

endpackage

// File: rtl/calendar_date_stepper.sv
// Top level of the calendar date stepper: a Gregorian date register driven by
// a command stream. Depends on cds_pkg.
//
// The block holds a date (day, month, year from 1900 up to 2^YEAR_BITS - 1)
// and takes one command word on the slave-side stream: load a date, step one
// day forward or step one day back. For every command word it returns exactly
// one result word holding the date after the command, with two flags in
// tuser. A load is taken only if the offered date is valid (month 1 to 12,
// day within the month, February 29 only in leap years, year in range);
// otherwise the date is kept and accepted stays low. Stepping back from
// 1 January 1900 leaves that date in place and raises clamped; stepping
// forward from 31 December of the largest year holds the date and raises
// clamped. The unused command code changes nothing and raises neither flag.
// A new command word is taken every clock cycle while the result side is not
// stalled; each word passes through an input register and then a result
// register, from which its result word is offered. Between those two
// registers sits the single-pass update logic (the date compare, increment
// and decrement, and two constant multiplies for the divisible-by-25 part of
// the leap test of the current and of the loaded year). When the year is
// wider than 16 bits, only its low 16 bits are shown on the output.
module calendar_date_stepper #(
    parameter int YEAR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command word.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [4:0] load_day, [8:5] load_month,
                                       // [24:9] load_year, [31:25] zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
    // Result word.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [4:0] day_out, [8:5] month_out,
                                       // [24:9] year_out, [31:25] zero
    output logic [1:0]  m_axis_tuser   // [0] accepted, [1] clamped
);
    import cds_pkg::*;

    // Largest and smallest year, at register width and zero-extended.
    localparam logic [YEAR_BITS-1:0] YearMax  = '1;
    localparam logic [31:0]          YearMax32 = 32'(YearMax);
    localparam logic [YEAR_BITS-1:0] YearBase = YEAR_BITS'(BASE_YEAR);

    // Input register.
    logic        r_in_valid;
    logic [1:0]  r_in_cmd;
    logic [4:0]  r_in_day;
    logic [3:0]  r_in_month;
    logic [15:0] r_in_year;

    // Date state.
    logic [4:0]           r_cur_day,   n_day;
    logic [3:0]           r_cur_month, n_month;
    logic [YEAR_BITS-1:0] r_cur_year,  n_year;

    // Result register.
    logic        r_out_valid;
    logic [4:0]  r_out_day;
    logic [3:0]  r_out_month;
    logic [15:0] r_out_year;
    logic        r_out_acc,  n_acc;
    logic        r_out_clp,  n_clp;

    logic        advance;
    logic        fire;
    logic        cur_leap;
    logic [4:0]  cur_len;
    logic [4:0]  prev_len;
    logic [31:0] ld_year32;
    logic        ld_leap;
    logic        load_ok;
    logic [31:0] year_ext;

    // The result register can take a new word when it is empty or being
    // emptied; the input register moves on at the same moment.
    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        cur_leap  = leap_year(32'(r_cur_year));
        cur_len   = month_days(r_cur_month, cur_leap);
        prev_len  = month_days(r_cur_month - 4'd1, cur_leap);

        ld_year32 = {16'd0, r_in_year};
        ld_leap   = leap_year(ld_year32);
        load_ok   = (r_in_month >= MONTH_JAN) && (r_in_month <= MONTH_DEC) &&
                    (ld_year32 >= 32'(BASE_YEAR)) && (ld_year32 <= YearMax32) &&
                    (r_in_day != 5'd0) &&
                    (r_in_day <= month_days(r_in_month, ld_leap));

        n_day   = r_cur_day;
        n_month = r_cur_month;
        n_year  = r_cur_year;
        n_acc   = 1'b0;
        n_clp   = 1'b0;

        case (r_in_cmd)
            CMD_LOAD: begin
                if (load_ok) begin
                    n_day   = r_in_day;
                    n_month = r_in_month;
                    n_year  = ld_year32[YEAR_BITS-1:0];
                    n_acc   = 1'b1;
                end
            end
            CMD_FWD: begin
                if (r_cur_day < cur_len) begin
                    n_day = r_cur_day + 5'd1;
                    n_acc = 1'b1;
                end else if (r_cur_month < MONTH_DEC) begin
                    n_day   = 5'd1;
                    n_month = r_cur_month + 4'd1;
                    n_acc   = 1'b1;
                end else if (r_cur_year < YearMax) begin
                    n_day   = 5'd1;
                    n_month = MONTH_JAN;
                    n_year  = r_cur_year + YEAR_BITS'(1);
                    n_acc   = 1'b1;
                end else begin
                    // Last day of the largest year: hold.
                    n_clp = 1'b1;
                end
            end
            CMD_BACK: begin
                if (r_cur_day > 5'd1) begin
                    n_day = r_cur_day - 5'd1;
                    n_acc = 1'b1;
                end else if (r_cur_month > MONTH_JAN) begin
                    n_month = r_cur_month - 4'd1;
                    n_day   = prev_len;
                    n_acc   = 1'b1;
                end else if (r_cur_year > YearBase) begin
                    n_year  = r_cur_year - YEAR_BITS'(1);
                    n_month = MONTH_DEC;
                    n_day   = DAYS_31;
                    n_acc   = 1'b1;
                end else begin
                    // Below the first day of the base year: pin to it.
                    n_day   = 5'd1;
                    n_month = MONTH_JAN;
                    n_year  = YearBase;
                    n_clp   = 1'b1;
                end
            end
            default: begin
            end
        endcase

        year_ext = 32'(n_year);
    end

    // Control state and the date.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur_day   <= 5'd1;
            r_cur_month <= MONTH_JAN;
            r_cur_year  <= YearBase;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_cur_day   <= n_day;
                r_cur_month <= n_month;
                r_cur_year  <= n_year;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd   <= s_axis_tuser;
            r_in_day   <= s_axis_tdata[4:0];
            r_in_month <= s_axis_tdata[8:5];
            r_in_year  <= s_axis_tdata[24:9];
        end
        if (fire) begin
            r_out_day   <= n_day;
            r_out_month <= n_month;
            r_out_year  <= year_ext[15:0];
            r_out_acc   <= n_acc;
            r_out_clp   <= n_clp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_year, r_out_month, r_out_day};
    assign m_axis_tuser  = {r_out_clp, r_out_acc};

endmodule

// File: rtl/cds_checker.sv
// Port-level checks for the calendar date stepper, and the bind that attaches
// them to every instance of its top level. Depends on nothing else.
module cds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A result is never both applied and clamped.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("accepted and clamped both set");

    // Day and month on the output always form a plausible date.
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4:0] != 5'd0) && (m_axis_tdata[8:5] != 4'd0) &&
                          (m_axis_tdata[8:5] <= 4'd12))
        else $error("day or month out of range");

    // A clamp only happens on the first day of January or the last of December.
    a_clamp_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |->
            ((m_axis_tdata[4:0] == 5'd1) && (m_axis_tdata[8:5] == 4'd1)) ||
            ((m_axis_tdata[4:0] == 5'd31) && (m_axis_tdata[8:5] == 4'd12)))
        else $error("clamped result not at a year boundary");

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/sv/calendar_date_checker.sv
// Scoreboard for the calendar date stepper: watches both stream channels,
// predicts the date word for each command word and compares the two.
// Depends on cds_pkg for the command codes.
`timescale 1ns / 100ps

module calendar_date_checker
    import cds_pkg::*;
#(
    parameter int YEAR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_tvalid,
    input  logic        i_cmd_tready,
    input  logic [31:0] i_cmd_tdata,   // [4:0] load_day, [8:5] load_month,
                                       // [24:9] load_year, [31:25] zero
    input  logic [1:0]  i_cmd_tuser,   // [1:0] cmd
    input  logic        i_date_tvalid,
    input  logic        i_date_tready,
    input  logic [31:0] i_date_tdata,  // [4:0] day_out, [8:5] month_out,
                                       // [24:9] year_out, [31:25] zero
    input  logic [1:0]  i_date_tuser,  // [0] accepted, [1] clamped
    output int          o_fail_count,
    output int          o_pending
);

    localparam longint unsigned YEAR_TOP = (64'd1 << YEAR_BITS) - 1;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
        logic        accepted;
        logic        clamped;
    } t_date_report;

    // The predicted calendar register.
    logic [4:0]           cal_day;
    logic [3:0]           cal_month;
    logic [YEAR_BITS-1:0] cal_year;

    t_date_report dates_due[$];
    int           fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = dates_due.size();

    function automatic bit gregorian_leap(input longint unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m,
                                                  input longint unsigned y);
        if (m == 2) begin
            return gregorian_leap(y) ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    // Applies one command to the predicted date and returns the word that the
    // block should send back for it.
    function automatic t_date_report apply_command(input logic [1:0] cmd,
                                                   input logic [4:0] ld,
                                                   input logic [3:0] lm,
                                                   input logic [15:0] ly);
        t_date_report rep;
        rep.accepted = 1'b0;
        rep.clamped  = 1'b0;
        case (t_cmd'(cmd))
            CMD_LOAD: begin
                if (lm >= 1 && lm <= 12 && ly >= BASE_YEAR && ly <= YEAR_TOP
                        && ld >= 1 && ld <= days_in_month(lm, ly)) begin
                    cal_day      = ld;
                    cal_month    = lm;
                    cal_year     = YEAR_BITS'(ly);
                    rep.accepted = 1'b1;
                end
            end
            CMD_FWD: begin
                if (cal_day < days_in_month(cal_month, cal_year)) begin
                    cal_day      = cal_day + 5'd1;
                    rep.accepted = 1'b1;
                end else if (cal_month < 12) begin
                    cal_day      = 5'd1;
                    cal_month    = cal_month + 4'd1;
                    rep.accepted = 1'b1;
                end else if (cal_year < YEAR_TOP) begin
                    cal_day      = 5'd1;
                    cal_month    = 4'd1;
                    cal_year     = cal_year + YEAR_BITS'(1);
                    rep.accepted = 1'b1;
                end else begin
                    rep.clamped = 1'b1;
                end
            end
            CMD_BACK: begin
                if (cal_day > 1) begin
                    cal_day      = cal_day - 5'd1;
                    rep.accepted = 1'b1;
                end else if (cal_month > 1) begin
                    cal_month    = cal_month - 4'd1;
                    cal_day      = 5'(days_in_month(cal_month, cal_year));
                    rep.accepted = 1'b1;
                end else if (cal_year > BASE_YEAR) begin
                    cal_year     = cal_year - YEAR_BITS'(1);
                    cal_month    = 4'd12;
                    cal_day      = 5'd31;
                    rep.accepted = 1'b1;
                end else begin
                    // Underflow below the first supported day pins the date.
                    cal_day     = 5'd1;
                    cal_month   = 4'd1;
                    cal_year    = YEAR_BITS'(BASE_YEAR);
                    rep.clamped = 1'b1;
                end
            end
            default: begin
            end
        endcase
        rep.day   = cal_day;
        rep.month = cal_month;
        rep.year  = 16'(32'(cal_year));
        return rep;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        cal_day    = 5'd1;
        cal_month  = 4'd1;
        cal_year   = YEAR_BITS'(BASE_YEAR);
    end

    always @(posedge i_clk) begin
        t_date_report want;
        if (!i_rst_n) begin
            cal_day   = 5'd1;
            cal_month = 4'd1;
            cal_year  = YEAR_BITS'(BASE_YEAR);
            dates_due.delete();
        end else begin
            // The outgoing word is matched before this edge's command is
            // queued, so it can only be paired with an older expectation.
            if (i_date_tvalid && i_date_tready) begin
                if (dates_due.size() == 0) begin
                    $error("date word with no command outstanding: %h/%b",
                           i_date_tdata, i_date_tuser);
                    fail_count++;
                end else begin
                    want = dates_due.pop_front();
                    compare_field("day_out", want.day, i_date_tdata[4:0]);
                    compare_field("month_out", want.month, i_date_tdata[8:5]);
                    compare_field("year_out", want.year, i_date_tdata[24:9]);
                    compare_field("accepted", want.accepted, i_date_tuser[0]);
                    compare_field("clamped", want.clamped, i_date_tuser[1]);
                end
            end
            if (i_cmd_tvalid && i_cmd_tready) begin
                dates_due.push_back(apply_command(i_cmd_tuser, i_cmd_tdata[4:0],
                                                  i_cmd_tdata[8:5],
                                                  i_cmd_tdata[24:9]));
            end
        end
    end

endmodule

// File: tb/sv/tb_calendar_date_stepper.sv
// Top of the calendar date stepper testbench: clock, reset, command stimulus
// and the verdict. Depends on cds_pkg, the block and calendar_date_checker.
`timescale 1ns / 100ps

module tb_calendar_date_stepper;
    import cds_pkg::*;

    // The one code that the block must treat as doing nothing.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int WORDS_PER_PHASE = 200;
    localparam int DRAIN_CYCLES    = 8;
    // Far beyond the longest correct stretch without a handshake, even in the
    // phases where one side idles half of the time.
    localparam int WATCHDOG_LIMIT  = 5000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;  // [4:0] load_day, [8:5] load_month,
                                      // [24:9] load_year, [31:25] zero
    logic [1:0]  s_axis_tuser  = '0;  // [1:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [4:0] day_out, [8:5] month_out,
                                      // [24:9] year_out, [31:25] zero
    logic [1:0]  m_axis_tuser;        // [0] accepted, [1] clamped

    int fail_count;
    int dates_pending;
    int send_idle_pct   = 0;
    int ready_stall_pct = 0;
    int words_sent      = 0;
    int quiet_cycles    = 0;

    always #5 i_clk = ~i_clk;

    calendar_date_stepper DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    calendar_date_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_tvalid (s_axis_tvalid),
        .i_cmd_tready (s_axis_tready),
        .i_cmd_tdata  (s_axis_tdata),
        .i_cmd_tuser  (s_axis_tuser),
        .i_date_tvalid(m_axis_tvalid),
        .i_date_tready(m_axis_tready),
        .i_date_tdata (m_axis_tdata),
        .i_date_tuser (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (dates_pending)
    );

    // The receiver drops tready at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // The watchdog counts cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offers one command word and returns at the edge that accepts it. The
    // sender may idle first; tvalid is left high so that back-to-back words
    // follow without a gap.
    task automatic send_word(input logic [1:0] cmd, input logic [4:0] day,
                             input logic [3:0] month, input logic [15:0] year);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, year, month, day};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    task automatic load_date(input logic [4:0] day, input logic [3:0] month,
                             input logic [15:0] year);
        send_word(CMD_LOAD, day, month, year);
    endtask

    // A step carries random load fields, which the block must ignore.
    task automatic step_date(input logic [1:0] cmd);
        logic [31:0] junk;
        junk = $urandom;
        send_word(cmd, junk[4:0], junk[8:5], junk[24:9]);
    endtask

    // Years chosen to hit the interesting corners: the first supported
    // years, the top of the range, century years, the years around 2000 and anything at all.
    function automatic logic [15:0] pick_year();
        case ($urandom_range(4))
            0: return 16'(BASE_YEAR + $urandom_range(3));
            1: return 16'(65535 - $urandom_range(2));
            2: return 16'(BASE_YEAR + 100 * $urandom_range(600));
            3: return 16'(1999 + $urandom_range(30));
            default: return 16'($urandom_range(65535, BASE_YEAR));
        endcase
    endfunction

    // One episode: a load, mostly of a plausible date near a month boundary,
    // then a run of steps that lean in one direction so that month, year and
    // range edges are actually crossed.
    task automatic run_episode();
        logic [31:0] noise;
        logic [1:0]  lean;
        int          run_len;
        case ($urandom_range(9))
            0, 1: begin
                noise = $urandom;
                load_date(noise[4:0], noise[8:5], noise[24:9]);
            end
            2: begin
                load_date(5'($urandom_range(31)), 4'($urandom_range(15)),
                          16'($urandom_range(BASE_YEAR + 1)));
            end
            default: begin
                // Days 28 to 31 are sometimes invalid for the month, which is
                // wanted: it keeps rejected loads in the mix.
                load_date(($urandom_range(1)) ? 5'($urandom_range(31, 28))
                                              : 5'($urandom_range(28, 1)),
                          ($urandom_range(3) == 0) ? MONTH_FEB
                              : ($urandom_range(3) == 0) ? MONTH_DEC
                              : ($urandom_range(3) == 0) ? MONTH_JAN
                              : 4'($urandom_range(12, 1)),
                          pick_year());
            end
        endcase
        lean    = $urandom_range(1) ? CMD_FWD : CMD_BACK;
        run_len = $urandom_range(40, 1);
        repeat (run_len) begin
            case ($urandom_range(19))
                0:       step_date(CMD_UNUSED);
                1, 2, 3: step_date((lean == CMD_FWD) ? CMD_BACK : CMD_FWD);
                default: step_date(lean);
            endcase
        end
    endtask

    task automatic run_directed();
        // From the reset date, one day back must clamp.
        step_date(CMD_BACK);
        step_date(CMD_FWD);
        step_date(CMD_BACK);
        step_date(CMD_BACK);
        // Leap days: a year divisible by 400, a century year, an ordinary
        // leap year and a common year.
        load_date(5'd29, MONTH_FEB, 16'd2000);
        load_date(5'd29, MONTH_FEB, 16'd1900);
        load_date(5'd29, MONTH_FEB, 16'd2024);
        load_date(5'd29, MONTH_FEB, 16'd2023);
        // Rejected loads: day past a 30-day month, day zero, month zero,
        // month past December, every field at its top, year below range.
        load_date(5'd31, 4'd4, 16'd2001);
        load_date(5'd0, 4'd5, 16'd2001);
        load_date(5'd15, 4'd0, 16'd2001);
        load_date(5'd15, 4'd13, 16'd2001);
        load_date(5'd31, 4'd15, 16'd65535);
        load_date(5'd15, 4'd6, 16'd1899);
        // Last day of the largest year: forward holds, back moves.
        load_date(5'd31, MONTH_DEC, 16'd65535);
        step_date(CMD_FWD);
        step_date(CMD_BACK);
        step_date(CMD_FWD);
        step_date(CMD_FWD);
        // Back across the end of February in a century year and a 400 year.
        load_date(5'd1, 4'd3, 16'd2100);
        step_date(CMD_BACK);
        load_date(5'd1, 4'd3, 16'd2000);
        step_date(CMD_BACK);
        // Back and forth across a year boundary, then the unused code.
        load_date(5'd1, MONTH_JAN, 16'd1901);
        step_date(CMD_BACK);
        step_date(CMD_FWD);
        step_date(CMD_UNUSED);
    endtask

    initial begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        int phase_end;
        idle_by_phase  = '{0, 50, 0, 20};
        stall_by_phase = '{0, 0, 50, 20};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct   = idle_by_phase[phase];
            ready_stall_pct = stall_by_phase[phase];
            if (phase == 0) begin
                run_directed();
            end
            phase_end = words_sent + WORDS_PER_PHASE;
            while (words_sent < phase_end) begin
                run_episode();
            end
        end
        s_axis_tvalid <= 1'b0;

        // Let every outstanding date word come back, then wait out the drain
        // period so that any stray word would show.
        wait (dates_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && dates_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/cds_pkg.sv
rtl/calendar_date_stepper.sv
rtl/cds_checker.sv
tb/sv/calendar_date_checker.sv
tb/sv/tb_calendar_date_stepper.sv
